FILE: rtl/igen_pkg.sv
// Shared types, constants and codes for the IPv4 header generator.
`default_nettype none

package igen_pkg;

    // Header layout
    localparam int unsigned HDR_WORDS      = 10;
    localparam int unsigned IDX_W          = 4;
    localparam logic [15:0] HDR_BYTES      = 16'd20;
    localparam logic [15:0] WORD_VER_IHL   = 16'h4500;
    localparam logic [15:0] WORD_FLAGS_DF  = 16'h4000;
    localparam logic [7:0]  TTL_VALUE      = 8'd64;
    localparam logic [15:0] WORD_TTL_BASE  = {TTL_VALUE, 8'h00};
    // Sum of the constant header words (version/IHL, flags, TTL byte)
    localparam logic [17:0] HDR_CONST_SUM  =
        {2'b00, WORD_VER_IHL} + {2'b00, WORD_FLAGS_DF} + {2'b00, WORD_TTL_BASE};

    // Word positions within the header
    localparam logic [IDX_W-1:0] IDX_VER_IHL = 4'd0;
    localparam logic [IDX_W-1:0] IDX_TOTAL   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_IDENT   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_FLAGS   = 4'd3;
    localparam logic [IDX_W-1:0] IDX_TTL     = 4'd4;
    localparam logic [IDX_W-1:0] IDX_CSUM    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_SRC_HI  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_SRC_LO  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_DST_HI  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_DST_LO  = 4'd9;

    // Configuration register indexes
    localparam int unsigned     CFG_IDX_W        = 1;
    localparam int unsigned     CFG_DATA_W       = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFLOAD   = 1'd1;
    localparam logic [15:0]     MAX_FRAME_RESET  = 16'd1500;

    // Default depth of the descriptor queue
    localparam int unsigned IGEN_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROUTE = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // Input transaction
    typedef struct packed {
        logic        route_found;
        logic [31:0] given_source;
        logic [31:0] route_source;
        logic [31:0] dest_address;
        logic [15:0] payload_length;
        logic [7:0]  protocol;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        status_t          status;
        logic [15:0]      header_word;
        logic [IDX_W-1:0] word_index;
        logic             last;
    } out_item_t;

    // Classified request handed from front to back
    typedef struct packed {
        status_t     status;
        logic [15:0] total;
        logic [15:0] ident;
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [31:0] dst;
        logic [17:0] hdr_sum;
        logic [17:0] addr_sum;
    } desc_t;

endpackage

`default_nettype wire

FILE: rtl/igen_front.sv
// Front end: accepts requests, checks route and length, assigns identification.
`default_nettype none

module igen_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  igen_pkg::in_item_t    s_data,
    input  wire  [15:0]           max_frame_length,
    output logic                  push_valid,
    input  wire                   push_ready,
    output igen_pkg::desc_t       push_data
);
    import igen_pkg::*;

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_item_reg;
    logic [15:0] next_id_reg, next_id_next;

    logic [16:0] total;
    logic        too_long;
    logic [31:0] src;
    status_t     status;
    logic        push_fire;

    // Classification of the held request
    always_comb begin
        total    = {1'b0, in_item_reg.payload_length} + {1'b0, HDR_BYTES};
        too_long = !(total < {1'b0, max_frame_length});
        src      = (in_item_reg.given_source != 32'd0) ? in_item_reg.given_source
                                                       : in_item_reg.route_source;
        if (!in_item_reg.route_found) begin
            status = ST_NO_ROUTE;
        end else if (too_long) begin
            status = ST_TOO_LONG;
        end else begin
            status = ST_OK;
        end
    end

    // Descriptor with partial checksum sums
    always_comb begin
        push_data.status   = status;
        push_data.total    = total[15:0];
        push_data.ident    = next_id_reg;
        push_data.protocol = in_item_reg.protocol;
        push_data.src      = src;
        push_data.dst      = in_item_reg.dest_address;
        push_data.hdr_sum  = HDR_CONST_SUM + {2'b00, total[15:0]}
                           + {2'b00, next_id_reg} + {10'd0, in_item_reg.protocol};
        push_data.addr_sum = {2'b00, src[31:16]} + {2'b00, src[15:0]}
                           + {2'b00, in_item_reg.dest_address[31:16]}
                           + {2'b00, in_item_reg.dest_address[15:0]};
    end

    // Handshake: input stage refills as soon as it drains
    assign push_valid = in_valid_reg;
    assign push_fire  = in_valid_reg && push_ready;
    assign s_ready    = !in_valid_reg || push_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (push_fire) begin
            in_valid_next = 1'b0;
        end
        next_id_next = next_id_reg;
        if (push_fire && (status == ST_OK)) begin
            next_id_next = next_id_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            next_id_reg  <= 16'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            next_id_reg  <= next_id_next;
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/igen_queue.sv
// Small descriptor queue between the front and back ends.
`default_nettype none

module igen_queue #(
    parameter int unsigned DEPTH = igen_pkg::IGEN_QUEUE_DEPTH
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push_valid,
    output logic               push_ready,
    input  igen_pkg::desc_t    push_data,
    output logic               pop_valid,
    input  wire                pop_ready,
    output igen_pkg::desc_t    pop_data
);
    import igen_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/igen_back.sv
// Back end: finishes the checksum and streams header words or one error result.
`default_nettype none

module igen_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  checksum_offload,
    input  wire                  pop_valid,
    output logic                 pop_ready,
    input  igen_pkg::desc_t      pop_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output igen_pkg::out_item_t  m_data
);
    import igen_pkg::*;

    desc_t            cur_reg;
    logic [15:0]      csum_reg, csum_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             out_free, emit, last_word, load;
    logic [18:0]      sum_full;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    logic [15:0]      word;

    // Folded ones' complement checksum of the incoming descriptor, or zero when offloaded
    always_comb begin
        sum_full  = {1'b0, pop_data.hdr_sum} + {1'b0, pop_data.addr_sum};
        fold1     = {14'd0, sum_full[18:16]} + {1'b0, sum_full[15:0]};
        fold2     = fold1[15:0] + {15'd0, fold1[16]};
        csum_next = checksum_offload ? 16'd0 : ~fold2;
    end

    // Sequencing
    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign last_word = (cur_reg.status != ST_OK) || (idx_reg == IDX_DST_LO);
    assign pop_ready = !busy_reg || (emit && last_word);
    assign load      = pop_valid && pop_ready;

    // Header word select
    always_comb begin
        case (idx_reg)
            IDX_VER_IHL: word = WORD_VER_IHL;
            IDX_TOTAL:   word = cur_reg.total;
            IDX_IDENT:   word = cur_reg.ident;
            IDX_FLAGS:   word = WORD_FLAGS_DF;
            IDX_TTL:     word = WORD_TTL_BASE | {8'd0, cur_reg.protocol};
            IDX_CSUM:    word = csum_reg;
            IDX_SRC_HI:  word = cur_reg.src[31:16];
            IDX_SRC_LO:  word = cur_reg.src[15:0];
            IDX_DST_HI:  word = cur_reg.dst[31:16];
            IDX_DST_LO:  word = cur_reg.dst[15:0];
            default:     word = 16'd0;
        endcase
    end

    // Next state of sequencer and output register
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (emit) begin
            if (last_word) begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        out_next = out_reg;
        if (emit) begin
            out_next.status = cur_reg.status;
            out_next.last   = last_word;
            if (cur_reg.status == ST_OK) begin
                out_next.header_word = word;
                out_next.word_index  = idx_reg;
            end else begin
                out_next.header_word = 16'd0;
                out_next.word_index  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (load) begin
            cur_reg  <= pop_data;
            csum_reg <= csum_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/ipv4_header_generator.sv
// Top level: configuration registers and the front / queue / back chain.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   igen_pkg::in_item_t (one send request)
//   m_        out        m_valid / m_ready   igen_pkg::out_item_t (one header word or error)
//   cfg_      in         cfg_wr_en           cfg_index, cfg_data (write only)
//
// A good request yields ten results, an error one result; the back end's
// one-word-per-cycle output, unless m_ready stalls it, sets the sustained rate.
// A request moves from the front input register through the queue into cur_reg.
// Reset is synchronous, active low, and clears control state and the id counter.
// The front and back stall independently; the queue absorbs up to QUEUE_DEPTH requests.
`default_nettype none

module ipv4_header_generator #(
    parameter int unsigned QUEUE_DEPTH = igen_pkg::IGEN_QUEUE_DEPTH
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  igen_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output igen_pkg::out_item_t                   m_data,
    input  wire                                   cfg_wr_en,
    input  wire  [igen_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [igen_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import igen_pkg::*;

    logic [15:0] max_frame_reg, max_frame_next;
    logic        offload_reg, offload_next;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    desc_t push_data, pop_data;

    // Configuration register writes
    always_comb begin
        max_frame_next = max_frame_reg;
        offload_next   = offload_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_FRAME: max_frame_next = cfg_data[15:0];
                CFG_OFFLOAD:   offload_next   = cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= MAX_FRAME_RESET;
            offload_reg   <= 1'b0;
        end else begin
            max_frame_reg <= max_frame_next;
            offload_reg   <= offload_next;
        end
    end

    igen_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .max_frame_length (max_frame_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    igen_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    igen_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .checksum_offload (offload_reg),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_data         (pop_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

endmodule

`default_nettype wire
